### rtl/core/tsam_pkg.sv
// ----------------------------------------------------------------------------
// tsam_pkg
// shared constants, command codes and payload layouts of the time slot alarm
// ----------------------------------------------------------------------------
`default_nettype none

package tsam_pkg;

   // table depth and derived widths
   localparam int SLOTS       = 8;
   localparam int SLOT_ADDR_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;
   localparam int CNT_W       = ($clog2(SLOTS + 1) > 4) ? $clog2(SLOTS + 1) : 4;
   localparam logic [CNT_W-1:0] SLOTS_C = CNT_W'(SLOTS);

   // time constants
   localparam logic [10:0]        MIN_PER_DAY = 11'd1440;
   localparam logic signed [12:0] NO_DISTANCE = 13'sd1441;
   localparam logic [6:0]         NO_MINUTE   = 7'd127;

   typedef enum logic [1:0] {
      CMD_TICK       = 2'd0,
      CMD_SET_ENABLE = 2'd1,
      CMD_WRITE_SLOT = 2'd2,
      CMD_READ_SLOT  = 2'd3
   } command_type;

   // one table entry, hour in the low bits
   typedef struct packed {
      logic [15:0] duration;
      logic [5:0]  minute;
      logic [4:0]  hour;
   } slot_entry_type;

   localparam int ENTRY_W = $bits(slot_entry_type);

   // request payload, last field lowest
   typedef struct packed {
      logic [3:0]  pad;
      logic [15:0] slot_duration;
      logic [5:0]  slot_minute;
      logic [4:0]  slot_hour;
      logic [2:0]  slot_index;
      logic        enable_value;
      logic        pump_running;
      logic [5:0]  now_minute;
      logic [4:0]  now_hour;
      logic        time_synced;
   } req_data_type;

   // response payload, last field lowest
   typedef struct packed {
      logic        pad;
      logic [15:0] read_duration;
      logic [5:0]  read_minute;
      logic [4:0]  read_hour;
      logic        read_ok;
      logic [10:0] minutes_until;
      logic [15:0] next_duration;
      logic [5:0]  next_minute;
      logic [4:0]  next_hour;
      logic        next_valid;
      logic [15:0] fire_duration;
      logic [2:0]  fire_slot;
      logic        fire;
   } rsp_data_type;

   localparam int REQ_DATA_W = $bits(req_data_type);
   localparam int RSP_DATA_W = $bits(rsp_data_type);

   // hour * 60 + minute on raw bits, at most 1923
   function automatic logic [10:0] minute_of_day(input logic [4:0] hour,
                                                 input logic [5:0] minute);
      minute_of_day = {hour, 6'b0} - {4'b0, hour, 2'b0} + {5'b0, minute};
   endfunction

endpackage

`default_nettype wire

### rtl/core/tsam_ram.sv
// ----------------------------------------------------------------------------
// tsam_ram
// generic single write port, single read port ram with registered read
// ----------------------------------------------------------------------------
`default_nettype none

module tsam_ram #(
   parameter int  WIDTH  = 8,
   parameter int  DEPTH  = 8,
   localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  wire logic              clock,
   input  wire logic              wr_en,
   input  wire logic [ADDR_W-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]  wr_data,
   input  wire logic              rd_en,
   input  wire logic [ADDR_W-1:0] rd_addr,
   output logic      [WIDTH-1:0]  rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

### rtl/core/time_slot_alarm_matcher_core.sv
// sequencing: an accepted transaction walks every slot in use through the
//   single read port in ST_SCAN, then ST_DONE loads the response register
//   once it is free; one transaction at a time, no request taken until idle
// reset: synchronous, clears control state, enable and last seen minute; the
//   slot table is not cleared and holds nothing defined until written
// ----------------------------------------------------------------------------
// time_slot_alarm_matcher_core
// multi-slot time-of-day alarm: fires the first matching slot once per new
// minute and reports the nearest upcoming slot and a slot readback
// ----------------------------------------------------------------------------
`default_nettype none

module time_slot_alarm_matcher_core
   import tsam_pkg::*;
(
   input  wire logic                  clock,
   input  wire logic                  reset,
   // request channel
   input  wire logic                  req_tvalid,
   output logic                       req_tready,
   // time_synced, now_hour, now_minute, pump_running, enable_value,
   // slot_index, slot_hour, slot_minute, slot_duration, zero pad
   input  wire logic [REQ_DATA_W-1:0] req_tdata,
   // command
   input  wire logic [1:0]            req_tuser,
   // response channel
   output logic                       rsp_tvalid,
   input  wire logic                  rsp_tready,
   // fire, fire_slot, fire_duration, next_valid, next_hour, next_minute,
   // next_duration, minutes_until, read_ok, read_hour, read_minute,
   // read_duration, zero pad
   output logic      [RSP_DATA_W-1:0] rsp_tdata,
   // slot_count register
   input  wire logic                  csr_wr_en,
   input  wire logic [3:0]            csr_wr_data
);

   // sequencer states
   typedef enum logic [2:0] {
      ST_IDLE = 3'b001,
      ST_SCAN = 3'b010,
      ST_DONE = 3'b100
   } state_type;

   req_data_type req;
   command_type  req_cmd;
   logic         req_accept;

   // control registers
   state_type        state_ff, state_in;
   logic [CNT_W-1:0] slot_count_ff, slot_count_in;
   logic [6:0]       last_seen_ff, last_seen_in;
   logic             enabled_ff, enabled_in;
   logic [CNT_W-1:0] issue_cnt_ff, issue_cnt_in;
   logic             rd_valid_ff, rd_valid_in;
   logic             rsp_valid_ff, rsp_valid_in;

   // item registers latched at acceptance
   command_type      cmd_ff;
   logic             synced_ff;
   logic [4:0]       hour_ff;
   logic [5:0]       minute_ff;
   logic [CNT_W-1:0] idx_ff;
   logic [10:0]      cur_mod_ff;
   logic             fire_en_ff;

   // scan accumulators
   logic [CNT_W-1:0]     rd_idx_ff, rd_idx_in;
   logic                 fire_ff, fire_in;
   logic [2:0]           fire_slot_ff, fire_slot_in;
   logic [15:0]          fire_dur_ff, fire_dur_in;
   logic                 found_ff, found_in;
   logic signed [12:0]   best_ff, best_in;
   slot_entry_type       best_ent_ff, best_ent_in;
   logic                 read_hit_ff, read_hit_in;
   slot_entry_type       read_ent_ff, read_ent_in;

   rsp_data_type rsp_ff, rsp_in;

   // memory port signals
   logic                 mem_wr_en;
   logic                 mem_rd_en;
   logic [ENTRY_W-1:0]   mem_rd_data;
   slot_entry_type       ent;
   slot_entry_type       wr_ent;
   logic [CNT_W-1:0]     req_idx;

   // per-entry arithmetic
   logic [10:0]        ent_mod;
   logic signed [12:0] dist_raw;
   logic signed [12:0] slot_gap;
   logic               rd_done;

   assign req       = req_data_type'(req_tdata);
   assign req_cmd   = command_type'(req_tuser);
   assign req_tready = (state_ff == ST_IDLE);
   assign req_accept = req_tvalid && req_tready;
   assign req_idx   = CNT_W'(req.slot_index);

   // write slot goes into the table in the cycle of acceptance, so the scan
   // that follows already sees the new entry
   assign mem_wr_en = req_accept && (req_cmd == CMD_WRITE_SLOT) && (req_idx < SLOTS_C);
   assign wr_ent    = '{duration: req.slot_duration, minute: req.slot_minute,
                        hour: req.slot_hour};

   // one read per cycle while slots in use remain
   assign mem_rd_en = (state_ff == ST_SCAN) && (issue_cnt_ff < slot_count_ff);

   tsam_ram #(
      .WIDTH (ENTRY_W),
      .DEPTH (SLOTS)
   ) u_slot_table (
      .clock   (clock),
      .wr_en   (mem_wr_en),
      .wr_addr (req_idx[SLOT_ADDR_W-1:0]),
      .wr_data (wr_ent),
      .rd_en   (mem_rd_en),
      .rd_addr (issue_cnt_ff[SLOT_ADDR_W-1:0]),
      .rd_data (mem_rd_data)
   );

   assign ent = slot_entry_type'(mem_rd_data);

   // circular distance from now to the entry, wrapped once by a day
   assign ent_mod  = minute_of_day(ent.hour, ent.minute);
   assign dist_raw = $signed({2'b00, ent_mod}) - $signed({2'b00, cur_mod_ff});
   assign slot_gap = (dist_raw <= 13'sd0) ? (dist_raw + $signed({2'b00, MIN_PER_DAY}))
                                          : dist_raw;

   // scan drained: nothing left to issue, nothing in flight
   assign rd_done = !mem_rd_en && !rd_valid_ff;

   always_comb begin
      state_in      = state_ff;
      slot_count_in = slot_count_ff;
      last_seen_in  = last_seen_ff;
      enabled_in    = enabled_ff;
      issue_cnt_in  = issue_cnt_ff;
      rd_valid_in   = 1'b0;
      rd_idx_in     = rd_idx_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_tready;
      rsp_in        = rsp_ff;
      fire_in       = fire_ff;
      fire_slot_in  = fire_slot_ff;
      fire_dur_in   = fire_dur_ff;
      found_in      = found_ff;
      best_in       = best_ff;
      best_ent_in   = best_ent_ff;
      read_hit_in   = read_hit_ff;
      read_ent_in   = read_ent_ff;

      // slot_count saturates at the table depth
      if (csr_wr_en) begin
         slot_count_in = (CNT_W'(csr_wr_data) > SLOTS_C) ? SLOTS_C : CNT_W'(csr_wr_data);
      end

      case (state_ff)
         ST_IDLE: begin
            if (req_accept) begin
               state_in     = ST_SCAN;
               issue_cnt_in = '0;
               fire_in      = 1'b0;
               fire_slot_in = '0;
               fire_dur_in  = '0;
               found_in     = 1'b0;
               best_in      = NO_DISTANCE;
               best_ent_in  = '0;
               read_hit_in  = 1'b0;
               read_ent_in  = '0;
               // a new synced minute is consumed by a tick; set enable
               // consumes the current minute when synced
               if ((req_cmd == CMD_TICK) && req.time_synced &&
                   ({1'b0, req.now_minute} != last_seen_ff)) begin
                  last_seen_in = {1'b0, req.now_minute};
               end
               if (req_cmd == CMD_SET_ENABLE) begin
                  enabled_in = req.enable_value;
                  if (req.time_synced) begin
                     last_seen_in = {1'b0, req.now_minute};
                  end
               end
            end
         end
         ST_SCAN: begin
            if (mem_rd_en) begin
               issue_cnt_in = issue_cnt_ff + CNT_W'(1);
               rd_valid_in  = 1'b1;
               rd_idx_in    = issue_cnt_ff;
            end
            if (rd_valid_ff) begin
               // first matching slot fires
               if (fire_en_ff && !fire_ff && (ent.hour == hour_ff) &&
                   (ent.minute == minute_ff)) begin
                  fire_in      = 1'b1;
                  fire_slot_in = rd_idx_ff[2:0];
                  fire_dur_in  = ent.duration;
               end
               // strict compare keeps the lower index on a tie
               if (slot_gap < best_ff) begin
                  best_in     = slot_gap;
                  best_ent_in = ent;
                  found_in    = 1'b1;
               end
               if ((cmd_ff == CMD_READ_SLOT) && (rd_idx_ff == idx_ff)) begin
                  read_hit_in = 1'b1;
                  read_ent_in = ent;
               end
            end
            if (rd_done) begin
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            // wait for the output register to free up
            if (!rsp_valid_ff || rsp_tready) begin
               state_in                = ST_IDLE;
               rsp_valid_in            = 1'b1;
               rsp_in                  = '0;
               rsp_in.fire             = fire_ff;
               rsp_in.fire_slot        = fire_slot_ff;
               rsp_in.fire_duration    = fire_dur_ff;
               if (synced_ff && found_ff) begin
                  rsp_in.next_valid    = 1'b1;
                  rsp_in.next_hour     = best_ent_ff.hour;
                  rsp_in.next_minute   = best_ent_ff.minute;
                  rsp_in.next_duration = best_ent_ff.duration;
                  rsp_in.minutes_until = best_ff[10:0];
               end
               if (read_hit_ff) begin
                  rsp_in.read_ok       = 1'b1;
                  rsp_in.read_hour     = read_ent_ff.hour;
                  rsp_in.read_minute   = read_ent_ff.minute;
                  rsp_in.read_duration = read_ent_ff.duration;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         slot_count_ff <= '0;
         last_seen_ff  <= NO_MINUTE;
         enabled_ff    <= 1'b0;
         issue_cnt_ff  <= '0;
         rd_valid_ff   <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         slot_count_ff <= slot_count_in;
         last_seen_ff  <= last_seen_in;
         enabled_ff    <= enabled_in;
         issue_cnt_ff  <= issue_cnt_in;
         rd_valid_ff   <= rd_valid_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   // payload and accumulators
   always_ff @(posedge clock) begin
      if (req_accept) begin
         cmd_ff     <= req_cmd;
         synced_ff  <= req.time_synced;
         hour_ff    <= req.now_hour;
         minute_ff  <= req.now_minute;
         idx_ff     <= req_idx;
         cur_mod_ff <= minute_of_day(req.now_hour, req.now_minute);
         // only a tick on a new synced minute, enabled and pump idle, may fire
         fire_en_ff <= (req_cmd == CMD_TICK) && req.time_synced &&
                       ({1'b0, req.now_minute} != last_seen_ff) &&
                       enabled_ff && !req.pump_running;
      end
      rd_idx_ff    <= rd_idx_in;
      fire_ff      <= fire_in;
      fire_slot_ff <= fire_slot_in;
      fire_dur_ff  <= fire_dur_in;
      found_ff     <= found_in;
      best_ff      <= best_in;
      best_ent_ff  <= best_ent_in;
      read_hit_ff  <= read_hit_in;
      read_ent_ff  <= read_ent_in;
      rsp_ff       <= rsp_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_ff;

   // an accepted request always starts a table walk
   a_accept_scan: assert property (@(posedge clock) disable iff (reset)
      req_accept |=> (state_ff == ST_SCAN))
      else $error("accepted transaction did not start a scan");

   // read data only follows a read issued during the scan
   a_read_origin: assert property (@(posedge clock) disable iff (reset)
      rd_valid_ff |-> $past(state_ff == ST_SCAN))
      else $error("read data outside a scan");

   // a new response only comes out of the completion state
   a_rsp_origin: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && !$past(rsp_tvalid)) |-> $past(state_ff == ST_DONE))
      else $error("response raised outside completion");

   // nothing in flight while waiting for a request
   a_idle_clean: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_IDLE) |-> !rd_valid_ff)
      else $error("read pending while idle");

endmodule

`default_nettype wire
